/* rtl/swb_pkg.sv */
// ----------------------------------------------------------------------------
// swb_pkg: shared types and constants of the separable weighted blur
// Holds the command queue entry, the geometry view of the configuration
// and the tap weight function used by the sequencer.
// ----------------------------------------------------------------------------
package swb_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_QUALITY = 3'd3;
    localparam logic [2:0] REG_SHAPE   = 3'd4;
    localparam logic [2:0] REG_DEGRADE = 3'd5;

    // Operation codes of the input item.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Kernel shape codes.
    localparam logic [1:0] SHAPE_BOX      = 2'd0;
    localparam logic [1:0] SHAPE_SQ_TENT  = 2'd1;
    localparam logic [1:0] SHAPE_LIN_TENT = 2'd2;

    // Quality codes.
    localparam logic [1:0] QUAL_LOW  = 2'd0;
    localparam logic [1:0] QUAL_STD  = 2'd1;
    localparam logic [1:0] QUAL_HIGH = 2'd2;

    // Radius limits of the low and standard quality levels.
    localparam int LIMIT_LOW = 4;
    localparam int LIMIT_STD = 16;

    // Arithmetic widths: radius below 64, weight up to 64 squared,
    // at most 127 taps per pass.
    localparam int RAD_W = 6;
    localparam int WT_W  = 13;
    localparam int TOT_W = 19;
    localparam int ACC_W = TOT_W + 8;

    // What the back end does with a queued item.
    typedef enum logic [1:0] {
        K_LOAD,
        K_ZERO,
        K_BLUR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  col;
        logic [8:0]  row;
        logic [31:0] pix;
        logic [7:0]  cov;
    } t_cmd;

    // Effective geometry derived from the configuration registers.
    typedef struct packed {
        logic [9:0]       w;
        logic [9:0]       h;
        logic [RAD_W-1:0] radius;
        logic [1:0]       shape;
    } t_cfg;

    // Weight of a tap at distance tap_dist from the center.
    function automatic logic [WT_W-1:0] f_weight(input logic [RAD_W-1:0] radius,
                                                 input logic [RAD_W-1:0] tap_dist,
                                                 input logic [1:0] shape);
        logic [RAD_W:0] v;
        v = {1'b0, radius} + 1'b1 - {1'b0, tap_dist};
        if (shape == SHAPE_BOX || radius == '0) begin
            return WT_W'(1);
        end else if (shape == SHAPE_SQ_TENT) begin
            return WT_W'(v) * WT_W'(v);
        end else begin
            return WT_W'(v);
        end
    endfunction

    // Clamp a signed sample position to 0 .. last.
    function automatic logic [9:0] f_clamp(input logic signed [10:0] p,
                                           input logic [9:0] last);
        if (p < 0) begin
            return 10'd0;
        end else if (p > $signed({1'b0, last})) begin
            return last;
        end else begin
            return p[9:0];
        end
    endfunction

endpackage

/* rtl/separable_weighted_blur.sv */
// ----------------------------------------------------------------------------
// separable_weighted_blur: weighted blur over a stored ARGB region
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_stall     operation, column, row,
//                                              source_pixel, coverage
//   output    out        o_valid / i_stall     blurred_pixel, write_enable
//   config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// A load item is written to the store straight from the queue. A blur item
// with radius R makes one store read per tap, and an eight-step divider runs
// after each row and after the vertical pass. Reset is synchronous and active
// low; the pixel store is not cleared. A two-entry queue decouples input
// acceptance from the sequencer, and the output register lets load items go
// on while a result waits.
// ----------------------------------------------------------------------------
module separable_weighted_blur #(
    parameter int MAX_REGION_WIDTH = 512,
    parameter int MAX_REGION_HEIGHT = 512,
    parameter int MAX_RADIUS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [8:0]  i_column,
    input  logic [8:0]  i_row,
    input  logic [31:0] i_source_pixel,
    input  logic [7:0]  i_coverage,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_blurred_pixel,
    output logic        o_write_enable,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic [9:0]    r_width;
    logic [9:0]    r_height;
    logic [5:0]    r_req_radius;
    logic [1:0]    r_quality;
    logic [1:0]    r_shape;
    logic          r_degraded;

    swb_pkg::t_cfg w_cfg;
    logic [6:0]    w_limit;
    logic          w_q_valid;
    swb_pkg::t_cmd w_q_cmd;
    logic          w_q_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 10'd1;
            r_height     <= 10'd1;
            r_req_radius <= 6'd0;
            r_quality    <= swb_pkg::QUAL_STD;
            r_shape      <= swb_pkg::SHAPE_BOX;
            r_degraded   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swb_pkg::REG_WIDTH:   r_width      <= i_cfg_data;
                swb_pkg::REG_HEIGHT:  r_height     <= i_cfg_data;
                swb_pkg::REG_RADIUS:  r_req_radius <= i_cfg_data[5:0];
                swb_pkg::REG_QUALITY: r_quality    <= i_cfg_data[1:0];
                swb_pkg::REG_SHAPE:   r_shape      <= i_cfg_data[1:0];
                swb_pkg::REG_DEGRADE: r_degraded   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective region size and radius.
    always_comb begin
        if (r_quality == swb_pkg::QUAL_LOW) begin
            w_limit = 7'(swb_pkg::LIMIT_LOW);
        end else if (r_quality == swb_pkg::QUAL_STD) begin
            w_limit = 7'(swb_pkg::LIMIT_STD);
        end else begin
            w_limit = 7'(MAX_RADIUS);
        end
        if (r_degraded && w_limit > 7'(swb_pkg::LIMIT_LOW)) begin
            w_limit = 7'(swb_pkg::LIMIT_LOW);
        end

        if (r_width == 10'd0) begin
            w_cfg.w = 10'd1;
        end else if (32'(r_width) > MAX_REGION_WIDTH) begin
            w_cfg.w = 10'(MAX_REGION_WIDTH);
        end else begin
            w_cfg.w = r_width;
        end
        if (r_height == 10'd0) begin
            w_cfg.h = 10'd1;
        end else if (32'(r_height) > MAX_REGION_HEIGHT) begin
            w_cfg.h = 10'(MAX_REGION_HEIGHT);
        end else begin
            w_cfg.h = r_height;
        end
        w_cfg.radius = ({1'b0, r_req_radius} < w_limit) ? r_req_radius : w_limit[5:0];
        w_cfg.shape  = r_shape;
    end

    swb_front #(
        .MAX_REGION_WIDTH (MAX_REGION_WIDTH),
        .MAX_REGION_HEIGHT(MAX_REGION_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_source_pixel(i_source_pixel),
        .i_coverage    (i_coverage),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    swb_back #(
        .MAX_REGION_WIDTH (MAX_REGION_WIDTH),
        .MAX_REGION_HEIGHT(MAX_REGION_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_blurred_pixel(o_blurred_pixel),
        .o_write_enable (o_write_enable)
    );

endmodule

/* rtl/swb_ram.sv */
// ----------------------------------------------------------------------------
// swb_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/swb_div.sv */
// ----------------------------------------------------------------------------
// swb_div: four-lane rounding divider
// Divides four channel sums by one weight total with rounding half up.
// The quotient is known to fit in eight bits, so eight steps suffice.
// ----------------------------------------------------------------------------
module swb_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [3:0][swb_pkg::ACC_W-1:0]     i_dividend,
    input  logic [swb_pkg::TOT_W-1:0]          i_divisor,
    output logic                               o_done,
    output logic [31:0]                        o_quot
);

    logic [3:0][swb_pkg::ACC_W-1:0] r_rem;
    logic [swb_pkg::TOT_W-1:0]      r_den;
    logic [3:0][7:0]                r_quot;
    logic [2:0]                     r_step;
    logic                           r_busy;
    logic                           r_done;
    logic [swb_pkg::ACC_W-1:0]      w_shift;

    // Divisor aligned to the current quotient bit.
    assign w_shift = swb_pkg::ACC_W'(r_den) << r_step;

    // One quotient bit per lane and cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd7;
                r_den  <= i_divisor;
                r_quot <= '0;
                for (int c = 0; c < 4; c++) begin
                    r_rem[c] <= i_dividend[c] + swb_pkg::ACC_W'(i_divisor >> 1);
                end
            end else if (r_busy) begin
                for (int c = 0; c < 4; c++) begin
                    if (r_rem[c] >= w_shift) begin
                        r_rem[c]          <= r_rem[c] - w_shift;
                        r_quot[c][r_step] <= 1'b1;
                    end
                end
                if (r_step == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/swb_front.sv */
// ----------------------------------------------------------------------------
// swb_front: input acceptance, classification and command queue
// Sorts each item into load, zero-coverage or blur work, drops items that
// fall outside the store or the region, and queues the rest.
// ----------------------------------------------------------------------------
module swb_front #(
    parameter int MAX_REGION_WIDTH = 512,
    parameter int MAX_REGION_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swb_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [8:0]           i_column,
    input  logic [8:0]           i_row,
    input  logic [31:0]          i_source_pixel,
    input  logic [7:0]           i_coverage,
    output logic                 o_q_valid,
    output swb_pkg::t_cmd        o_q_cmd,
    input  logic                 i_q_pop
);

    swb_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    swb_pkg::t_cmd w_cmd;
    logic          w_keep;
    logic          w_push;

    // Classification of the incoming item.
    always_comb begin
        w_cmd.col  = i_column;
        w_cmd.row  = i_row;
        w_cmd.pix  = i_source_pixel;
        w_cmd.cov  = i_coverage;
        w_cmd.kind = swb_pkg::K_LOAD;
        w_keep     = 1'b0;
        if (i_operation == swb_pkg::OP_LOAD) begin
            w_keep = (32'(i_column) < MAX_REGION_WIDTH) && (32'(i_row) < MAX_REGION_HEIGHT);
        end else begin
            w_keep     = ({1'b0, i_column} < i_cfg.w) && ({1'b0, i_row} < i_cfg.h);
            w_cmd.kind = (i_coverage == 8'd0) ? swb_pkg::K_ZERO : swb_pkg::K_BLUR;
        end
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    // Two-entry queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

/* rtl/swb_back.sv */
// ----------------------------------------------------------------------------
// swb_back: pixel store and blur sequencer
// Writes load items into the store and runs the horizontal and vertical
// weighted passes for blur items, one store read per cycle while a row runs.
// ----------------------------------------------------------------------------
module swb_back #(
    parameter int MAX_REGION_WIDTH = 512,
    parameter int MAX_REGION_HEIGHT = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swb_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  swb_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_blurred_pixel,
    output logic           o_write_enable
);

    localparam int DEPTH  = MAX_REGION_WIDTH * MAX_REGION_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HRUN,
        S_HDRAIN,
        S_HSTART,
        S_HDIV,
        S_VSTART,
        S_VDIV,
        S_ALPHA
    } t_state;

    t_state                          r_state;
    logic [8:0]                      r_col;
    logic [8:0]                      r_row;
    logic [7:0]                      r_cov;
    logic signed [swb_pkg::RAD_W:0]  r_dx;
    logic signed [swb_pkg::RAD_W:0]  r_dy;
    logic [swb_pkg::WT_W-1:0]        r_wt_p;
    logic                            r_p_vld;
    logic [3:0][swb_pkg::ACC_W-1:0]  r_hacc;
    logic [3:0][swb_pkg::ACC_W-1:0]  r_vacc;
    logic [swb_pkg::TOT_W-1:0]       r_htot;
    logic [swb_pkg::TOT_W-1:0]       r_vtot;
    logic [23:0]                     r_rgb;
    logic [15:0]                     r_amul;
    logic                            r_o_valid;
    logic [31:0]                     r_o_pixel;
    logic                            r_o_we;

    logic                            w_out_free;
    logic signed [swb_pkg::RAD_W:0]  w_rad_s;
    logic [9:0]                      w_sx;
    logic [9:0]                      w_sy;
    logic [31:0]                     w_raddr32;
    logic [31:0]                     w_waddr32;
    logic [ADDR_W-1:0]               w_raddr;
    logic [ADDR_W-1:0]               w_waddr;
    logic                            w_we;
    logic [31:0]                     w_rdata;
    logic [swb_pkg::RAD_W-1:0]       w_hdist;
    logic [swb_pkg::RAD_W-1:0]       w_vdist;
    logic [swb_pkg::WT_W-1:0]        w_vwt;
    logic                            w_div_start;
    logic [3:0][swb_pkg::ACC_W-1:0]  w_div_num;
    logic [swb_pkg::TOT_W-1:0]       w_div_den;
    logic                            w_div_done;
    logic [31:0]                     w_quot;
    logic [16:0]                     w_asum;

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_rad_s    = $signed({1'b0, i_cfg.radius});

    // Sample positions clamped to the region and their store address.
    assign w_sx = swb_pkg::f_clamp(11'(signed'({1'b0, r_col})) + 11'(r_dx), i_cfg.w - 10'd1);
    assign w_sy = swb_pkg::f_clamp(11'(signed'({1'b0, r_row})) + 11'(r_dy), i_cfg.h - 10'd1);
    assign w_raddr32 = 32'(w_sy) * 32'(MAX_REGION_WIDTH) + 32'(w_sx);
    assign w_waddr32 = 32'(i_q_cmd.row) * 32'(MAX_REGION_WIDTH) + 32'(i_q_cmd.col);
    assign w_raddr   = w_raddr32[ADDR_W-1:0];
    assign w_waddr   = w_waddr32[ADDR_W-1:0];
    assign w_we      = (r_state == S_IDLE) && i_q_valid && (i_q_cmd.kind == swb_pkg::K_LOAD);

    // Tap distances and the vertical weight.
    assign w_hdist = (r_dx < 0) ? swb_pkg::RAD_W'(-r_dx) : swb_pkg::RAD_W'(r_dx);
    assign w_vdist = (r_dy < 0) ? swb_pkg::RAD_W'(-r_dy) : swb_pkg::RAD_W'(r_dy);
    assign w_vwt   = swb_pkg::f_weight(i_cfg.radius, w_vdist, i_cfg.shape);

    // Queue pop: loads at once, zero coverage and blur when the output is free.
    always_comb begin
        o_q_pop = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            case (i_q_cmd.kind)
                swb_pkg::K_LOAD: o_q_pop = 1'b1;
                default:         o_q_pop = w_out_free;
            endcase
        end
    end

    // Divider operands for the two passes.
    assign w_div_start = (r_state == S_HSTART) || (r_state == S_VSTART);
    assign w_div_num   = (r_state == S_VSTART) ? r_vacc : r_hacc;
    assign w_div_den   = (r_state == S_VSTART) ? r_vtot : r_htot;

    // Exact floor of the alpha product over 255.
    assign w_asum = 17'(r_amul) + 17'(r_amul >> 8) + 17'd1;

    swb_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_q_cmd.pix),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    swb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_div_num),
        .i_divisor (w_div_den),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            // Accumulate the sample read in the previous cycle.
            r_p_vld <= 1'b0;
            if (r_p_vld) begin
                for (int c = 0; c < 4; c++) begin
                    r_hacc[c] <= r_hacc[c] +
                                 swb_pkg::ACC_W'(w_rdata[c*8 +: 8] * r_wt_p);
                end
                r_htot <= r_htot + swb_pkg::TOT_W'(r_wt_p);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && o_q_pop) begin
                        case (i_q_cmd.kind)
                            swb_pkg::K_ZERO: begin
                                r_o_valid <= 1'b1;
                                r_o_pixel <= 32'd0;
                                r_o_we    <= 1'b0;
                            end
                            swb_pkg::K_BLUR: begin
                                r_col   <= i_q_cmd.col;
                                r_row   <= i_q_cmd.row;
                                r_cov   <= i_q_cmd.cov;
                                r_dx    <= -w_rad_s;
                                r_dy    <= -w_rad_s;
                                r_hacc  <= '0;
                                r_htot  <= '0;
                                r_vacc  <= '0;
                                r_vtot  <= '0;
                                r_state <= S_HRUN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_HRUN: begin
                    r_wt_p  <= swb_pkg::f_weight(i_cfg.radius, w_hdist, i_cfg.shape);
                    r_p_vld <= 1'b1;
                    if (r_dx == w_rad_s) begin
                        r_state <= S_HDRAIN;
                    end else begin
                        r_dx <= r_dx + 1'b1;
                    end
                end
                S_HDRAIN: begin
                    r_state <= S_HSTART;
                end
                S_HSTART: begin
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    if (w_div_done) begin
                        for (int c = 0; c < 4; c++) begin
                            r_vacc[c] <= r_vacc[c] +
                                         swb_pkg::ACC_W'(w_quot[c*8 +: 8] * w_vwt);
                        end
                        r_vtot <= r_vtot + swb_pkg::TOT_W'(w_vwt);
                        if (r_dy == w_rad_s) begin
                            r_state <= S_VSTART;
                        end else begin
                            r_dy    <= r_dy + 1'b1;
                            r_dx    <= -w_rad_s;
                            r_hacc  <= '0;
                            r_htot  <= '0;
                            r_state <= S_HRUN;
                        end
                    end
                end
                S_VSTART: begin
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    if (w_div_done) begin
                        r_rgb   <= w_quot[23:0];
                        r_amul  <= 16'(w_quot[31:24]) * 16'(r_cov);
                        r_state <= S_ALPHA;
                    end
                end
                S_ALPHA: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_pixel <= {w_asum[15:8], r_rgb};
                        r_o_we    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_blurred_pixel = r_o_pixel;
    assign o_write_enable  = r_o_we;

endmodule

/* tb/tb_separable_weighted_blur.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_separable_weighted_blur: self-checking bench of the weighted blur
// Loads small pixel regions, then asks for blurred pixels under several
// radius, quality, shape and degraded settings. A behavioral predictor in
// the scoreboard class computes every expected pixel, and each result is
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_separable_weighted_blur;

    localparam int STORE_W = 512;
    localparam int STORE_H = 512;
    localparam int RADIUS_CAP = 32;

    // Codes beyond the named ones, used to check the fallback behavior.
    localparam logic [1:0] SHAPE_SPARE = 2'd3;
    localparam logic [1:0] QUAL_SPARE  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [8:0]  i_column = '0;
    logic [8:0]  i_row = '0;
    logic [31:0] i_source_pixel = '0;
    logic [7:0]  i_coverage = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_blurred_pixel;
    logic        o_write_enable;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    typedef struct {
        logic [31:0] pixel;
        logic        we;
    } t_blur_out;

    // Scoreboard with its own copy of the store and the registers.
    class blur_scoreboard;
        logic [31:0] pixels [int];
        logic [9:0]  width_reg;
        logic [9:0]  height_reg;
        logic [5:0]  radius_reg;
        logic [1:0]  quality_reg;
        logic [1:0]  shape_reg;
        logic        degrade_reg;
        t_blur_out   pending [$];
        int          errors;

        function new();
            width_reg = 10'd1;
            height_reg = 10'd1;
            radius_reg = '0;
            quality_reg = swb_pkg::QUAL_STD;
            shape_reg = swb_pkg::SHAPE_BOX;
            degrade_reg = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [9:0] val);
            case (idx)
                swb_pkg::REG_WIDTH:   width_reg = val;
                swb_pkg::REG_HEIGHT:  height_reg = val;
                swb_pkg::REG_RADIUS:  radius_reg = val[5:0];
                swb_pkg::REG_QUALITY: quality_reg = val[1:0];
                swb_pkg::REG_SHAPE:   shape_reg = val[1:0];
                swb_pkg::REG_DEGRADE: degrade_reg = val[0];
                default: ;
            endcase
        endfunction

        function int tap(int rad, int tap_dist);
            int v;
            v = rad + 1 - tap_dist;
            if (shape_reg == swb_pkg::SHAPE_BOX || rad == 0) return 1;
            if (shape_reg == swb_pkg::SHAPE_SQ_TENT) return v * v;
            return v;
        endfunction

        function int clampi(int p, int last);
            if (p < 0) return 0;
            if (p > last) return last;
            return p;
        endfunction

        function logic [31:0] stored(int c, int r);
            int key;
            key = r * STORE_W + c;
            return pixels.exists(key) ? pixels[key] : 32'd0;
        endfunction

        function logic [31:0] pack4(longint acc [4], longint tot);
            logic [31:0] p;
            for (int k = 0; k < 4; k++) p[31 - 8*k -: 8] = 8'((acc[k] + tot / 2) / tot);
            return p;
        endfunction

        function logic [31:0] row_pass(int c, int r, int rad, int w);
            longint acc [4];
            longint tot;
            logic [31:0] p;
            int wt;
            tot = 0;
            for (int k = 0; k < 4; k++) acc[k] = 0;
            for (int off = -rad; off <= rad; off++) begin
                p = stored(clampi(c + off, w - 1), r);
                wt = tap(rad, off < 0 ? -off : off);
                for (int k = 0; k < 4; k++) acc[k] += longint'(p[31 - 8*k -: 8]) * wt;
                tot += wt;
            end
            return pack4(acc, tot);
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            return width_reg > STORE_W ? STORE_W : int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            return height_reg > STORE_H ? STORE_H : int'(height_reg);
        endfunction

        // Note an accepted input item and queue its expected result, if it has one.
        function void note_input(logic op, logic [8:0] c, logic [8:0] r,
                                 logic [31:0] src, logic [7:0] cov);
            int w, h, rad, lim, wt;
            longint acc [4];
            longint tot;
            logic [31:0] p;
            t_blur_out e;
            if (op == swb_pkg::OP_LOAD) begin
                pixels[int'(r) * STORE_W + int'(c)] = src;
                return;
            end
            w = eff_width();
            h = eff_height();
            if (c >= w || r >= h) return;
            if (cov == 0) begin
                e.pixel = '0;
                e.we = 1'b0;
                pending.push_back(e);
                return;
            end
            lim = quality_reg == swb_pkg::QUAL_LOW ? swb_pkg::LIMIT_LOW :
                  quality_reg == swb_pkg::QUAL_STD ? swb_pkg::LIMIT_STD : RADIUS_CAP;
            if (degrade_reg && lim > swb_pkg::LIMIT_LOW) lim = swb_pkg::LIMIT_LOW;
            rad = radius_reg < lim ? int'(radius_reg) : lim;
            tot = 0;
            for (int k = 0; k < 4; k++) acc[k] = 0;
            for (int off = -rad; off <= rad; off++) begin
                p = row_pass(c, clampi(int'(r) + off, h - 1), rad, w);
                wt = tap(rad, off < 0 ? -off : off);
                for (int k = 0; k < 4; k++) acc[k] += longint'(p[31 - 8*k -: 8]) * wt;
                tot += wt;
            end
            p = pack4(acc, tot);
            e.pixel = {8'((int'(p[31:24]) * int'(cov)) / 255), p[23:0]};
            e.we = 1'b1;
            pending.push_back(e);
        endfunction

        // Compare one result with the oldest expectation.
        function void check_result(logic [31:0] pix, logic we);
            t_blur_out e;
            if (pending.size() == 0) begin
                $error("unexpected result blurred_pixel=%h write_enable=%b", pix, we);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (pix !== e.pixel) begin
                $error("blurred_pixel expected %h actual %h", e.pixel, pix);
                errors++;
            end
            if (we !== e.we) begin
                $error("write_enable expected %b actual %b", e.we, we);
                errors++;
            end
        endfunction
    endclass

    blur_scoreboard sb = new();

    separable_weighted_blur i_dut (.*);

    always #5 i_clk = ~i_clk;

    int stall_left = 0;

    // Output side: stall bursts, mostly short and a few long, and checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_blurred_pixel, o_write_enable);
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 9) < 2) begin
            i_stall <= 1'b1;
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 19);
        if (g < 12) return 0;
        if (g < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive one input item and hold it until accepted.
    task automatic send_item(logic op, logic [8:0] c, logic [8:0] r,
                             logic [31:0] src, logic [7:0] cov);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_column <= c;
        i_row <= r;
        i_source_pixel <= src;
        i_coverage <= cov;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(op, c, r, src, cov);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // A trailing load or out-of-region item may still be in flight.
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Load every pixel of a w by h region with random content.
    task automatic load_region(int w, int h);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_item(swb_pkg::OP_LOAD, 9'(c), 9'(r), $urandom(), 8'($urandom()));
    endtask

    task automatic setup(int w, int h, int rad, int q, int sh, int dg);
        drain();
        write_reg(swb_pkg::REG_WIDTH, 10'(w));
        write_reg(swb_pkg::REG_HEIGHT, 10'(h));
        write_reg(swb_pkg::REG_RADIUS, 10'(rad));
        write_reg(swb_pkg::REG_QUALITY, 10'(q));
        write_reg(swb_pkg::REG_SHAPE, 10'(sh));
        write_reg(swb_pkg::REG_DEGRADE, 10'(dg));
        i_cfg_we <= 1'b0;
    endtask

    task automatic blur_at(int c, int r, logic [7:0] cov);
        send_item(swb_pkg::OP_COMPUTE, 9'(c), 9'(r), $urandom(), cov);
    endtask

    initial begin
        int w, h;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, a single pixel region.
        load_region(1, 1);
        blur_at(0, 0, 8'd255);
        blur_at(0, 0, 8'd0);
        blur_at(1, 0, 8'd255);
        blur_at(0, 1, 8'd255);

        // Extremes of the load fields land far out in the store.
        send_item(swb_pkg::OP_LOAD, 9'd511, 9'd511, 32'hffffffff, 8'hff);
        send_item(swb_pkg::OP_LOAD, 9'd511, 9'd0, 32'h00000000, 8'h00);

        // Small region, every shape, radii up to the cap, clamped edges.
        setup(4, 3, 32, swb_pkg::QUAL_HIGH, swb_pkg::SHAPE_BOX, 0);
        load_region(4, 3);
        blur_at(0, 0, 8'd255);
        blur_at(3, 2, 8'd128);
        setup(4, 3, 63, QUAL_SPARE, swb_pkg::SHAPE_SQ_TENT, 0);
        blur_at(1, 1, 8'd1);
        blur_at(511, 511, 8'd255);
        setup(4, 3, 5, swb_pkg::QUAL_LOW, swb_pkg::SHAPE_LIN_TENT, 1);
        blur_at(2, 0, 8'd200);
        setup(4, 3, 20, swb_pkg::QUAL_STD, SHAPE_SPARE, 0);
        blur_at(3, 1, 8'd255);

        // Zero width and oversized height; the column reached by the window is loaded.
        setup(0, 1023, 10, swb_pkg::QUAL_HIGH, swb_pkg::SHAPE_LIN_TENT, 1);
        for (int r = 0; r < 8; r++)
            send_item(swb_pkg::OP_LOAD, 9'd0, 9'(r), $urandom(), 8'd0);
        blur_at(0, 2, 8'd77);
        blur_at(1, 0, 8'd77);

        // Sender holds off until every result is back.
        drain();

        // Random phases with small regions and random settings.
        for (int ph = 0; ph < 6; ph++) begin
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            setup(w, h, $urandom_range(0, 63), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 1));
            load_region(w, h);
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 9) == 0)
                    blur_at($urandom_range(0, 511), $urandom_range(0, 511), 8'($urandom()));
                else if ($urandom_range(0, 9) == 0)
                    blur_at($urandom_range(0, w - 1), $urandom_range(0, h - 1), 8'd0);
                else
                    blur_at($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                            $urandom_range(0, 1) ? 8'd255 : 8'($urandom()));
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog over the whole run.
    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

endmodule

/* separable_weighted_blur.f */
rtl/swb_pkg.sv
rtl/swb_ram.sv
rtl/swb_div.sv
rtl/swb_front.sv
rtl/swb_back.sv
rtl/separable_weighted_blur.sv
tb/tb_separable_weighted_blur.sv
